// ----- rtl/size_class_slab_allocator_macros.svh -----
// assertion macros for the slab allocator
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH

`define SCSA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("slab allocator check failed");

`define SCSA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("slab allocator check failed");

`endif

// ----- rtl/scsa_pkg.sv -----
`default_nettype none
package scsa_pkg;
    localparam int CLASS_COUNT_DEF = 8;
    localparam int POOL_PAGES_DEF  = 64;
    localparam int SLOTS_PER_PAGE  = 256;
    localparam int ADDR_W          = 48;
    localparam int BYTES_W         = 19;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_TOO_BIG  = 3'd2,
        ST_NO_PAGES = 3'd3,
        ST_BAD_PTR  = 3'd4,
        ST_NULL     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALOOK,
        S_REFILL,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_FIN,
        S_FREE_RD,
        S_FREE_WAIT,
        S_FREE_FIN,
        S_DONE
    } state_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] REG_PAGE_LIMIT = 2'd1;
endpackage
`default_nettype wire

// ----- rtl/scsa_slot_mem.sv -----
`default_nettype none
module scsa_slot_mem
    import scsa_pkg::*;
#(
    parameter int SLOT_W = 14
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [SLOT_W-1:0] waddr,
    input  wire logic [SLOT_W:0]   wdata,
    input  wire logic [SLOT_W-1:0] raddr,
    output logic      [SLOT_W:0]   rdata
);
    // link entry: {valid, next slot}
    logic [SLOT_W:0] mem [2**SLOT_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/size_class_slab_allocator.sv -----
// channel  | handshake          | payload
// command  | start / busy       | cmd, request_bytes, release_pointer
// result   | done (one cycle)   | granted_pointer, status, granted_class_bytes, bytes_in_use
// config   | APB psel/penable   | paddr, pwdata, prdata
// done follows S_FREE_RD/WAIT/FIN after a free is accepted, S_ALOOK and S_POP_RD/WAIT/FIN
// after an allocate from a non-empty stack, and S_IDLE directly after a rejected item;
// start is taken again in the cycle after done. A refill writes one block link per cycle.
// After reset a clearing pass walks all 2**SLOT_W allocated marks (16384 at 64 pages)
// with busy high. Results cannot be stalled.
`default_nettype none
`include "size_class_slab_allocator_macros.svh"
module size_class_slab_allocator
    import scsa_pkg::*;
#(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF,
    parameter int POOL_PAGES  = POOL_PAGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [31:0] request_bytes,
    input  wire logic [47:0] release_pointer,
    output logic             done,
    output logic      [47:0] granted_pointer,
    output logic      [2:0]  status,
    output logic      [11:0] granted_class_bytes,
    output logic      [18:0] bytes_in_use
);
    localparam int PG_W   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int SLOT_W = PG_W + 8;
    localparam int CNT_W  = $clog2(POOL_PAGES + 1);
    localparam int CLS_W  = 3;
    localparam int LIM_W  = (CNT_W > 7) ? CNT_W : 7;

    // configuration
    logic [47:0] heap_base_reg;
    logic [6:0]  page_limit_reg;
    logic        cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            page_limit_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_HEAP_BASE[0] && paddr[2:0] == 3'd0)
                heap_base_reg <= pwdata[47:0];
            else if (paddr[3] == REG_PAGE_LIMIT[0] && paddr[2:0] == 3'd0)
                page_limit_reg <= pwdata[6:0];
        end
    end

    always_comb
    begin
        case (paddr[3])
            REG_HEAP_BASE[0]:  prdata = {16'd0, heap_base_reg};
            default:           prdata = {57'd0, page_limit_reg};
        endcase
    end

    // state
    state_t                  state_reg, state_next;
    logic [SLOT_W:0]         tops_reg [CLASS_COUNT];
    logic [3:0]              pcls_mem [POOL_PAGES];
    logic [3:0]              pcls_q;
    logic [CNT_W-1:0]        pages_reg;
    logic [18:0]             total_reg;
    logic [CLS_W-1:0]        cls_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [PG_W-1:0]         page_reg;
    logic [8:0]              walk_reg;
    logic [SLOT_W:0]         clr_reg;
    logic                    live_mem [2**SLOT_W];
    logic                    live_q;
    logic [47:0]             optr_reg;
    logic [2:0]              ost_reg;
    logic [11:0]             ocb_reg;

    // decode of incoming item
    logic [32:0] need;
    logic [3:0]  acls;
    logic [47:0] base_al, blk, rel;
    logic [11:0] off;
    logic        page_ok, off_ok;
    logic [PG_W-1:0] fpage;
    logic [LIM_W-1:0] lim;
    logic        pages_left;
    logic        take_page;

    assign need    = {1'b0, request_bytes} + 33'd4;
    assign base_al = {heap_base_reg[47:12], 12'd0};
    assign blk     = release_pointer - 48'd4;
    assign rel     = blk - base_al;
    assign off     = rel[11:0];
    assign fpage   = rel[12 +: PG_W];
    assign page_ok = ({12'd0, rel[47:12]} < {{(48-CNT_W){1'b0}}, pages_reg})
                     && (rel[47:12] < 36'(POOL_PAGES));
    assign off_ok  = (off >= 12'd4) && (off[3:0] == 4'd4);
    assign lim     = (LIM_W'(page_limit_reg) < LIM_W'(POOL_PAGES)) ? LIM_W'(page_limit_reg)
                                                                    : LIM_W'(POOL_PAGES);
    assign pages_left = (LIM_W'(pages_reg) < lim);
    assign take_page  = (state_reg == S_ALOOK) && !tops_reg[cls_reg][SLOT_W] && pages_left;

    always_comb
    begin
        acls = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (i < CLASS_COUNT && need <= (33'd16 << i))
                acls = 4'(i);
        end
    end

    // link memory
    logic              lk_we;
    logic [SLOT_W-1:0] lk_waddr, lk_raddr;
    logic [SLOT_W:0]   lk_wdata, lk_rdata;

    scsa_slot_mem #(.SLOT_W(SLOT_W)) u_links (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    logic [11:0] csize;
    logic [8:0]  nblk;
    logic [SLOT_W-1:0] walk_slot;
    assign csize = 12'd16 << cls_reg;
    assign nblk  = 9'((13'd4092 >> (4 + cls_reg)));   // blocks per page
    assign walk_slot = {page_reg, 8'(walk_reg << cls_reg)};

    logic [SLOT_W-1:0] top_slot;
    assign top_slot = tops_reg[cls_reg][SLOT_W-1:0];

    always_comb
    begin
        lk_we    = 1'b0;
        lk_waddr = walk_slot;
        lk_wdata = tops_reg[cls_reg];
        lk_raddr = top_slot;
        case (state_reg)
            S_REFILL:
            begin
                lk_we = 1'b1;
            end
            S_FREE_FIN:
            begin
                lk_we    = live_q;
                lk_waddr = slot_reg;
            end
            default: ;
        endcase
    end

    // live marks
    logic live_we, live_wd;
    logic [SLOT_W-1:0] live_wa, live_ra;
    always_comb
    begin
        live_we = 1'b0;
        live_wd = 1'b0;
        live_wa = clr_reg[SLOT_W-1:0];
        live_ra = slot_reg;
        if (!clr_reg[SLOT_W])
            live_we = 1'b1;
        else if (state_reg == S_POP_FIN)
        begin
            live_we = 1'b1;
            live_wd = 1'b1;
            live_wa = top_slot;
        end
        else if (state_reg == S_FREE_FIN && live_q)
        begin
            live_we = 1'b1;
            live_wa = slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
            live_mem[live_wa] <= live_wd;
        live_q <= live_mem[live_ra];
    end

    // page class table: only entries of pages below pages_reg are ever used
    always_ff @(posedge clk)
    begin
        if (take_page)
            pcls_mem[pages_reg[PG_W-1:0]] <= {1'b0, cls_reg} + 4'd1;
        pcls_q <= pcls_mem[page_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && clr_reg[SLOT_W])
                begin
                    if (cmd == CMD_FREE)
                    begin
                        if (release_pointer == 48'd0 || !page_ok || !off_ok)
                            state_next = S_DONE;
                        else
                            state_next = S_FREE_RD;
                    end
                    else if (request_bytes == 32'd0 || acls[3])
                        state_next = S_DONE;
                    else
                        state_next = S_ALOOK;
                end
            end
            S_ALOOK:
            begin
                if (tops_reg[cls_reg][SLOT_W])
                    state_next = S_POP_RD;
                else if (!pages_left)
                    state_next = S_DONE;
                else
                    state_next = S_REFILL;
            end
            S_REFILL:
            begin
                if (walk_reg == nblk - 9'd1)
                    state_next = S_POP_RD;
            end
            S_POP_RD:    state_next = S_POP_WAIT;
            S_POP_WAIT:  state_next = S_POP_FIN;
            S_POP_FIN:   state_next = S_DONE;
            S_FREE_RD:   state_next = S_FREE_WAIT;
            S_FREE_WAIT: state_next = S_FREE_FIN;
            S_FREE_FIN:  state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE) || !clr_reg[SLOT_W];
        done = (state_reg == S_DONE);
    end

    assign granted_pointer     = optr_reg;
    assign status              = ost_reg;
    assign granted_class_bytes = ocb_reg;
    assign bytes_in_use        = total_reg;

    logic [2:0] fcls;
    assign fcls = pcls_q[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < CLASS_COUNT; i++)
                tops_reg[i] <= '0;
            pages_reg <= '0;
            total_reg <= '0;
            clr_reg   <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (!clr_reg[SLOT_W])
                clr_reg <= clr_reg + 1'b1;
            case (state_reg)
                S_ALOOK:
                begin
                    walk_reg <= '0;
                    if (take_page)
                        pages_reg <= pages_reg + 1'b1;
                end
                S_REFILL:
                begin
                    tops_reg[cls_reg] <= {1'b1, walk_slot};
                    walk_reg <= walk_reg + 9'd1;
                end
                S_POP_FIN:
                begin
                    tops_reg[cls_reg] <= lk_rdata;
                    total_reg <= total_reg + 19'(csize);
                end
                S_FREE_FIN:
                begin
                    if (live_q)
                    begin
                        tops_reg[cls_reg] <= {1'b1, slot_reg};
                        total_reg <= total_reg - 19'(csize);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cls_reg  <= acls[2:0];
                slot_reg <= {fpage, off[11:4]};
                page_reg <= fpage;
                optr_reg <= '0;
                ocb_reg  <= '0;
                if (cmd == CMD_FREE)
                begin
                    if (release_pointer == 48'd0)
                        ost_reg <= ST_NULL;
                    else
                        ost_reg <= ST_BAD_PTR;
                end
                else if (request_bytes == 32'd0)
                    ost_reg <= ST_ZERO;
                else if (acls[3])
                    ost_reg <= ST_TOO_BIG;
                else
                    ost_reg <= ST_NO_PAGES;
            end
            S_ALOOK:
            begin
                page_reg <= pages_reg[PG_W-1:0];
            end
            S_FREE_WAIT:
            begin
                cls_reg <= fcls - 3'd1;
            end
            S_FREE_FIN:
            begin
                if (live_q)
                begin
                    ost_reg <= ST_OK;
                    ocb_reg <= csize;
                end
            end
            S_POP_FIN:
            begin
                ost_reg  <= ST_OK;
                ocb_reg  <= csize;
                optr_reg <= base_al + {{(48-12-PG_W){1'b0}}, top_slot[SLOT_W-1:8], 12'd0}
                            + {36'd0, top_slot[7:0], 4'd0} + 48'd8;
            end
            default: ;
        endcase
    end

    `SCSA_ASSERT_IMPL(a_done_idle_next, clk, rst_n, done, state_next == S_IDLE)
    `SCSA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SCSA_ASSERT_IMPL(a_ok_class, clk, rst_n, done && status == ST_OK,
        granted_class_bytes != 12'd0)
endmodule
`default_nettype wire
